// ===== rtl/hbs_pkg.sv =====
// Package for the heartbeat supervisor: payload, state and configuration types,
// command/action/reason codes and the age helper.
// No dependencies; every other file in rtl/ imports it.
package hbs_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned CFG_W    = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned COUNT_W  = 8;

	// Input commands
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_POLL  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// Result actions
	localparam logic [1:0] ACT_NONE     = 2'd0;
	localparam logic [1:0] ACT_RESTART  = 2'd1;
	localparam logic [1:0] ACT_DEGRADED = 2'd2;
	localparam logic [1:0] ACT_FALLBACK = 2'd3;

	// Stall reasons
	localparam logic [2:0] RSN_NONE     = 3'd0;
	localparam logic [2:0] RSN_HOST     = 3'd1;
	localparam logic [2:0] RSN_CAP_TASK = 3'd2;
	localparam logic [2:0] RSN_CAP_FRM  = 3'd3;
	localparam logic [2:0] RSN_FRONTEND = 3'd4;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_HOST_STALL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAP_TASK      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAP_FRAME     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRONTEND      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEALTHY_WIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RESTART_LIMIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF       = 3'd6;

	// Register reset values
	localparam logic [TIME_W-1:0]  HOST_STALL_RST    = 32'd15000;
	localparam logic [TIME_W-1:0]  CAP_TASK_RST      = 32'd4000;
	localparam logic [TIME_W-1:0]  CAP_FRAME_RST     = 32'd6000;
	localparam logic [TIME_W-1:0]  FRONTEND_RST      = 32'd5000;
	localparam logic [TIME_W-1:0]  HEALTHY_WIN_RST   = 32'd120000;
	localparam logic [COUNT_W-1:0] RESTART_LIMIT_RST = 8'd3;
	localparam logic [TIME_W-1:0]  HOLDOFF_RST       = 32'd10000;

	localparam logic [TIME_W-1:0]  AGE_NEVER = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [TIME_W-1:0] now_ms;
		logic [TIME_W-1:0] capture_attempt_ms;
		logic [TIME_W-1:0] capture_frame_ms;
		logic              frontend_ready;
		logic [TIME_W-1:0] frontend_progress_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [2:0]         reason_code;
		logic [TIME_W-1:0]  stall_age_ms;
		logic               report_emit;
		logic               streak_cleared;
		logic [COUNT_W-1:0] recovery_total;
		logic [TIME_W-1:0]  boot_total;
		logic [TIME_W-1:0]  last_restart_ms;
		logic [2:0]         latest_reason;
	} out_item_t;

	typedef struct packed {
		logic [TIME_W-1:0]  host_stall_ms;
		logic [TIME_W-1:0]  capture_task_stall_ms;
		logic [TIME_W-1:0]  capture_frame_stall_ms;
		logic [TIME_W-1:0]  frontend_stall_ms;
		logic [TIME_W-1:0]  healthy_window_ms;
		logic [COUNT_W-1:0] restart_limit;
		logic [TIME_W-1:0]  report_holdoff_ms;
	} cfg_t;

	typedef struct packed {
		logic               running;
		logic               healthy_done;
		logic               report_valid;
		logic [TIME_W-1:0]  start_time;
		logic [TIME_W-1:0]  host_poll_time;
		logic [TIME_W-1:0]  last_report_time;
		logic [COUNT_W-1:0] streak_count;
		logic [TIME_W-1:0]  boot_tally;
		logic [TIME_W-1:0]  restart_time;
		logic [2:0]         restart_reason;
	} state_t;

	// Wrapping age of a heartbeat; a zero stamp was never seen
	function automatic logic [TIME_W-1:0] age_of(
		input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] stamp
	);
		logic [TIME_W-1:0] age;
		age = (stamp == '0) ? AGE_NEVER : now - stamp;
		return age;
	endfunction

endpackage

// ===== rtl/hbs_in_if.sv =====
// Input channel of the heartbeat supervisor: valid/ready plus one command beat.
// Depends on hbs_pkg.
interface hbs_in_if
	import hbs_pkg::*;
;
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/hbs_out_if.sv =====
// Result channel of the heartbeat supervisor: valid/ready plus one result beat.
// Depends on hbs_pkg.
interface hbs_out_if
	import hbs_pkg::*;
;
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/hbs_cfg_regs.sv =====
// Configuration register file of the heartbeat supervisor: write-only port,
// registers held with their reset defaults. Depends on hbs_pkg.
module hbs_cfg_regs
	import hbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Write the addressed register; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.host_stall_ms          <= HOST_STALL_RST;
			cfg_q.capture_task_stall_ms  <= CAP_TASK_RST;
			cfg_q.capture_frame_stall_ms <= CAP_FRAME_RST;
			cfg_q.frontend_stall_ms      <= FRONTEND_RST;
			cfg_q.healthy_window_ms      <= HEALTHY_WIN_RST;
			cfg_q.restart_limit          <= RESTART_LIMIT_RST;
			cfg_q.report_holdoff_ms      <= HOLDOFF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HOST_STALL:    cfg_q.host_stall_ms          <= cfg_data;
				REG_CAP_TASK:      cfg_q.capture_task_stall_ms  <= cfg_data;
				REG_CAP_FRAME:     cfg_q.capture_frame_stall_ms <= cfg_data;
				REG_FRONTEND:      cfg_q.frontend_stall_ms      <= cfg_data;
				REG_HEALTHY_WIN:   cfg_q.healthy_window_ms      <= cfg_data;
				REG_RESTART_LIMIT: cfg_q.restart_limit          <= cfg_data[COUNT_W-1:0];
				REG_HOLDOFF:       cfg_q.report_holdoff_ms      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/hbs_eval.sv =====
// Decision logic of the heartbeat supervisor: from one command beat, the
// current state and the registers, form the result and the next state.
// Depends on hbs_pkg.
module hbs_eval
	import hbs_pkg::*;
(
	input  in_item_t  item,
	input  state_t    st,
	input  cfg_t      cfg,
	output state_t    st_nxt,
	output out_item_t result
);

	logic [TIME_W-1:0] now;
	logic [TIME_W-1:0] age_host, age_task, age_frame, age_fe;
	logic              stall_host, stall_task, stall_frame, stall_fe;
	logic              heal, gate_open, below_limit;
	logic [COUNT_W-1:0] streak;

	// Ages and limit compares run side by side
	assign now         = item.now_ms;
	assign age_host    = age_of(now, st.host_poll_time);
	assign age_task    = age_of(now, item.capture_attempt_ms);
	assign age_frame   = age_of(now, item.capture_frame_ms);
	assign age_fe      = age_of(now, item.frontend_progress_ms);
	assign stall_host  = age_host > cfg.host_stall_ms;
	assign stall_task  = age_task > cfg.capture_task_stall_ms;
	assign stall_frame = age_frame > cfg.capture_frame_stall_ms;
	assign stall_fe    = item.frontend_ready && (age_fe > cfg.frontend_stall_ms);

	// Healthy window clears the streak once per start
	assign heal   = !st.healthy_done && ((now - st.start_time) >= cfg.healthy_window_ms);
	assign streak = heal ? '0 : st.streak_count;
	assign below_limit = streak < cfg.restart_limit;

	// Report holdoff: open if nothing reported since start or spacing met
	assign gate_open = !st.report_valid || ((now - st.last_report_time) >= cfg.report_holdoff_ms);

	always_comb begin
		logic [1:0]        action;
		logic [2:0]        reason;
		logic [TIME_W-1:0] age;
		logic              emit;
		logic              cleared;
		logic              use_gate;

		st_nxt   = st;
		action   = ACT_NONE;
		reason   = RSN_NONE;
		age      = '0;
		emit     = 1'b0;
		cleared  = 1'b0;
		use_gate = 1'b0;

		case (item.cmd)
			CMD_START: begin
				if (!st.running) begin
					st_nxt.running        = 1'b1;
					st_nxt.boot_tally     = st.boot_tally + 1'b1;
					st_nxt.start_time     = now;
					st_nxt.host_poll_time = now;
					st_nxt.healthy_done   = 1'b0;
					st_nxt.report_valid   = 1'b0;
				end
			end
			CMD_POLL: begin
				st_nxt.host_poll_time = now;
			end
			CMD_TICK: begin
				if (st.running) begin
					if (heal) begin
						st_nxt.healthy_done = 1'b1;
						cleared             = 1'b1;
					end
					st_nxt.streak_count = streak;

					// First stall in priority order decides the tick
					if (stall_host) begin
						action = ACT_RESTART;
						reason = RSN_HOST;
						age    = age_host;
					end else if (stall_task || stall_frame) begin
						reason = stall_task ? RSN_CAP_TASK : RSN_CAP_FRM;
						age    = stall_task ? age_task : age_frame;
						if (below_limit) begin
							action = ACT_RESTART;
						end else begin
							action   = ACT_DEGRADED;
							use_gate = 1'b1;
						end
					end else if (stall_fe) begin
						action   = ACT_FALLBACK;
						reason   = RSN_FRONTEND;
						age      = age_fe;
						use_gate = 1'b1;
					end

					if (use_gate && gate_open) begin
						emit                    = 1'b1;
						st_nxt.report_valid     = 1'b1;
						st_nxt.last_report_time = now;
					end

					// Restart: record it, bump the streak, disarm
					if (action == ACT_RESTART) begin
						if (streak != COUNT_MAX) begin
							st_nxt.streak_count = streak + 1'b1;
						end
						st_nxt.restart_time   = now;
						st_nxt.restart_reason = reason;
						st_nxt.running        = 1'b0;
					end
				end
			end
			default: ;
		endcase

		result.action          = action;
		result.reason_code     = reason;
		result.stall_age_ms    = age;
		result.report_emit     = emit;
		result.streak_cleared  = cleared;
		result.recovery_total  = st_nxt.streak_count;
		result.boot_total      = st_nxt.boot_tally;
		result.last_restart_ms = st_nxt.restart_time;
		result.latest_reason   = st_nxt.restart_reason;
	end

endmodule

// ===== rtl/multi_heartbeat_supervisor_unit.sv =====
// Heartbeat supervisor with escalation over host poll, capture task, capture
// frame and frontend progress. Each command beat is registered, decided in one
// pass of compare logic against the supervisor state, and its result registered
// for the output channel. An accepted beat waits in the input register until
// the result register is free or draining. One beat is accepted every cycle
// while the output drains; with the output stalled, one more beat is taken
// into the input register and then the input holds until the result register
// drains. The state update for one beat lands in the same edge that registers
// its result, so the next beat sees it. Configuration is written through a
// plain write port, by the user only while the block is idle; the block itself does not enforce it.
// Depends on hbs_pkg, hbs_in_if, hbs_out_if, hbs_cfg_regs and hbs_eval.
module multi_heartbeat_supervisor_unit
	import hbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	hbs_in_if.sink               req,
	hbs_out_if.source            rsp
);

	cfg_t      cfg;
	state_t    st_q, st_nxt;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result, result_s2;
	logic      valid_s2;
	logic      adv_s2;

	hbs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hbs_eval u_eval (
		.item   (item_s1),
		.st     (st_q),
		.cfg    (cfg),
		.st_nxt (st_nxt),
		.result (result)
	);

	// Advance stage 1 into the result register when it is free or draining
	assign adv_s2    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req.data;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			result_s2 <= result;
		end
	end

	// Supervisor state, committed with each decided beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv_s2) begin
			st_q <= st_nxt;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = result_s2;

	// A restart always leaves the block disarmed
	a_restart_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && (result.action == ACT_RESTART) |=> !st_q.running)
		else $error("restart did not disarm the supervisor");

	// Only degraded and fallback results carry a report
	a_emit_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.report_emit |->
			(rsp.data.action == ACT_DEGRADED) || (rsp.data.action == ACT_FALLBACK))
		else $error("report emitted on a result that is not degraded or fallback");

	// A cleared streak can only have been bumped once by this tick
	a_clear_streak: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.streak_cleared |-> rsp.data.recovery_total <= 8'd1)
		else $error("streak clear left a recovery count above one");

	// A full pipeline with a stalled output takes no new beat
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !rsp.ready |-> !req.ready)
		else $error("input accepted while both stages are held");

	// A restart result reports its reason as the latest one
	a_restart_record: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.data.action == ACT_RESTART) |->
			(rsp.data.latest_reason == rsp.data.reason_code)
			&& (rsp.data.reason_code != RSN_NONE))
		else $error("restart result does not record its reason");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for multi_heartbeat_supervisor_unit: drives command beats,
// predicts every supervisor verdict and compares each result beat field by field.
// Depends on hbs_pkg, hbs_in_if, hbs_out_if and the RTL of the supervisor.
module tb_top;
	import hbs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]  CMD_UNUSED  = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_WAIT  = 4;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	hbs_in_if  req_if ();
	hbs_out_if rsp_if ();

	multi_heartbeat_supervisor_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	// Shadow of the supervisor state and its limit registers
	state_t shadow;
	cfg_t   thresholds;

	in_item_t  pending_beats[$];
	out_item_t verdict_queue[$];

	logic              in_taken = 1'b0;
	int unsigned       fault_count = 0;
	int unsigned       cycle_count = 0;
	int unsigned       burst_left = 0;
	int unsigned       gap_left = 0;
	int unsigned       stall_tick = 0;
	int unsigned       stall_mode = 0;
	logic [TIME_W-1:0] scenario_ms;
	logic [TIME_W-1:0] host_mark_ms;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Age of a heartbeat stamp; a zero stamp was never seen
	function automatic logic [TIME_W-1:0] heartbeat_age(
		input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] stamp
	);
		logic [TIME_W-1:0] diff;
		diff = now - stamp;
		if (stamp == '0)
			return '1;
		return diff;
	endfunction

	// Holdoff on degraded and fallback reports; arms the holdoff when it passes
	function automatic logic report_due(input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] since;
		since = now - shadow.last_report_time;
		if (shadow.report_valid && since < thresholds.report_holdoff_ms)
			return 1'b0;
		shadow.report_valid = 1'b1;
		shadow.last_report_time = now;
		return 1'b1;
	endfunction

	// Apply one command beat to the shadow state and return the verdict it yields
	function automatic out_item_t supervise(input in_item_t beat);
		out_item_t         verdict;
		logic [TIME_W-1:0] age;
		logic [TIME_W-1:0] uptime;
		verdict = '0;
		case (beat.cmd)
			CMD_START: begin
				if (!shadow.running) begin
					shadow.running = 1'b1;
					shadow.boot_tally = shadow.boot_tally + 1'b1;
					shadow.start_time = beat.now_ms;
					shadow.host_poll_time = beat.now_ms;
					shadow.healthy_done = 1'b0;
					shadow.report_valid = 1'b0;
				end
			end
			CMD_POLL: begin
				shadow.host_poll_time = beat.now_ms;
			end
			CMD_TICK: begin
				if (shadow.running) begin
					// clear the streak once uptime reaches the healthy window
					uptime = beat.now_ms - shadow.start_time;
					if (!shadow.healthy_done && uptime >= thresholds.healthy_window_ms) begin
						shadow.healthy_done = 1'b1;
						shadow.streak_count = '0;
						verdict.streak_cleared = 1'b1;
					end
					// first stall in priority order decides the tick
					age = heartbeat_age(beat.now_ms, shadow.host_poll_time);
					if (age > thresholds.host_stall_ms) begin
						verdict.action = ACT_RESTART;
						verdict.reason_code = RSN_HOST;
						verdict.stall_age_ms = age;
					end else begin
						age = heartbeat_age(beat.now_ms, beat.capture_attempt_ms);
						if (age > thresholds.capture_task_stall_ms) begin
							verdict.reason_code = RSN_CAP_TASK;
							verdict.stall_age_ms = age;
						end else begin
							age = heartbeat_age(beat.now_ms, beat.capture_frame_ms);
							if (age > thresholds.capture_frame_stall_ms) begin
								verdict.reason_code = RSN_CAP_FRM;
								verdict.stall_age_ms = age;
							end
						end
						if (verdict.reason_code != RSN_NONE) begin
							if (shadow.streak_count < thresholds.restart_limit) begin
								verdict.action = ACT_RESTART;
							end else begin
								verdict.action = ACT_DEGRADED;
								verdict.report_emit = report_due(beat.now_ms);
							end
						end else if (beat.frontend_ready) begin
							age = heartbeat_age(beat.now_ms, beat.frontend_progress_ms);
							if (age > thresholds.frontend_stall_ms) begin
								verdict.action = ACT_FALLBACK;
								verdict.reason_code = RSN_FRONTEND;
								verdict.stall_age_ms = age;
								verdict.report_emit = report_due(beat.now_ms);
							end
						end
					end
					// record the restart and disarm until the next start
					if (verdict.action == ACT_RESTART) begin
						if (shadow.streak_count != COUNT_MAX)
							shadow.streak_count = shadow.streak_count + 1'b1;
						shadow.restart_time = beat.now_ms;
						shadow.restart_reason = verdict.reason_code;
						shadow.running = 1'b0;
					end
				end
			end
			default: ;
		endcase
		verdict.recovery_total = shadow.streak_count;
		verdict.boot_total = shadow.boot_tally;
		verdict.last_restart_ms = shadow.restart_time;
		verdict.latest_reason = shadow.restart_reason;
		return verdict;
	endfunction

	function automatic void check_field(
		input string             name,
		input logic [TIME_W-1:0] want,
		input logic [TIME_W-1:0] got
	);
		if (got !== want) begin
			fault_count++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	// Stamp that is fresh, within one of the limit, never seen, or anywhere
	function automatic logic [TIME_W-1:0] pick_stamp(
		input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] limit
	);
		logic [TIME_W-1:0] back;
		case ($urandom_range(0, 7))
			0: return '0;
			1, 2, 3: back = $urandom_range(0, limit >> 1);
			4, 5: back = limit + $urandom_range(0, 2) - 1;
			default: back = $urandom();
		endcase
		return now - back;
	endfunction

	function automatic cfg_t random_limits();
		cfg_t c;
		c.host_stall_ms = $urandom_range(1000, 20000);
		c.capture_task_stall_ms = $urandom_range(100, 5000);
		c.capture_frame_stall_ms = $urandom_range(100, 7000);
		c.frontend_stall_ms = $urandom_range(100, 6000);
		c.healthy_window_ms = $urandom_range(0, 60000);
		c.restart_limit = COUNT_W'($urandom_range(0, 6));
		c.report_holdoff_ms = $urandom_range(0, 20000);
		return c;
	endfunction

	task automatic push_beat(
		input logic [1:0]        cmd,
		input logic [TIME_W-1:0] now, att, frm,
		input logic              fe_ready,
		input logic [TIME_W-1:0] prog
	);
		in_item_t beat;
		beat.cmd = cmd;
		beat.now_ms = now;
		beat.capture_attempt_ms = att;
		beat.capture_frame_ms = frm;
		beat.frontend_ready = fe_ready;
		beat.frontend_progress_ms = prog;
		pending_beats.push_back(beat);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	// Write every limit register; only called while the block is idle
	task automatic apply_limits(input cfg_t c);
		logic [CFG_W-1:0] upper;
		upper = $urandom();
		write_reg(REG_HOST_STALL, c.host_stall_ms);
		write_reg(REG_CAP_TASK, c.capture_task_stall_ms);
		write_reg(REG_CAP_FRAME, c.capture_frame_stall_ms);
		write_reg(REG_FRONTEND, c.frontend_stall_ms);
		write_reg(REG_HEALTHY_WIN, c.healthy_window_ms);
		write_reg(REG_RESTART_LIMIT, {upper[CFG_W-1:COUNT_W], c.restart_limit});
		write_reg(REG_HOLDOFF, c.report_holdoff_ms);
		@(negedge clk);
		cfg_we <= 1'b0;
		thresholds = c;
	endtask

	// Boot sessions: a start, then polls and ticks with random stamps, plus noise
	task automatic queue_sessions(
		input int unsigned count,
		input int unsigned max_len,
		input int unsigned poll_pct
	);
		int unsigned       made;
		int unsigned       len;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] step_cap;
		made = 0;
		step_cap = (thresholds.host_stall_ms >> 2) + 3;
		while (made < count) begin
			if ($urandom_range(0, 99) < 8) begin
				push_beat(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(),
					1'($urandom_range(0, 1)), $urandom());
				made++;
			end else begin
				scenario_ms += $urandom_range(0, 1000);
				host_mark_ms = scenario_ms;
				push_beat(CMD_START, scenario_ms, $urandom(), $urandom(),
					1'($urandom_range(0, 1)), $urandom());
				len = $urandom_range(1, max_len);
				made += len + 1;
				repeat (len) begin
					if ($urandom_range(0, 99) < poll_pct) begin
						scenario_ms += $urandom_range(0, step_cap);
						host_mark_ms = scenario_ms;
						push_beat(CMD_POLL, scenario_ms, $urandom(), $urandom(),
							1'($urandom_range(0, 1)), $urandom());
					end else begin
						// now and then land right on the host limit
						if ($urandom_range(0, 9) == 0) begin
							now = host_mark_ms + thresholds.host_stall_ms
								+ $urandom_range(0, 2) - 1;
						end else begin
							scenario_ms += $urandom_range(0, step_cap);
							now = scenario_ms;
						end
						push_beat(CMD_TICK, now,
							pick_stamp(now, thresholds.capture_task_stall_ms),
							pick_stamp(now, thresholds.capture_frame_stall_ms),
							$urandom_range(0, 9) < 7,
							pick_stamp(now, thresholds.frontend_stall_ms));
					end
				end
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_beats.size() != 0 || req_if.valid || verdict_queue.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Send command beats in bursts with random gaps
	always @(negedge clk) begin
		if (arst_n && (!req_if.valid || in_taken)) begin
			if (gap_left != 0) begin
				gap_left--;
				req_if.valid <= 1'b0;
			end else if (pending_beats.size() != 0) begin
				req_if.data <= pending_beats.pop_front();
				req_if.valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
				end else begin
					burst_left--;
				end
			end else begin
				req_if.valid <= 1'b0;
			end
		end
		in_taken = 1'b0;
	end

	// Stall the result channel; the pattern is redrawn at random from four
	always @(negedge clk) begin
		stall_tick++;
		if (stall_tick % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: rsp_if.ready <= 1'b1;
			1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
			2: rsp_if.ready <= (stall_tick % 4 == 0);
			default: rsp_if.ready <= (stall_tick % 8 < 3);
		endcase
	end

	// Check result beats, then predict accepted command beats
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (verdict_queue.size() == 0) begin
					fault_count++;
					$error("result beat with no command outstanding");
				end else begin
					want = verdict_queue.pop_front();
					check_field("action", 32'(want.action), 32'(rsp_if.data.action));
					check_field("reason_code", 32'(want.reason_code),
						32'(rsp_if.data.reason_code));
					check_field("stall_age_ms", want.stall_age_ms, rsp_if.data.stall_age_ms);
					check_field("report_emit", 32'(want.report_emit),
						32'(rsp_if.data.report_emit));
					check_field("streak_cleared", 32'(want.streak_cleared),
						32'(rsp_if.data.streak_cleared));
					check_field("recovery_total", 32'(want.recovery_total),
						32'(rsp_if.data.recovery_total));
					check_field("boot_total", want.boot_total, rsp_if.data.boot_total);
					check_field("last_restart_ms", want.last_restart_ms,
						rsp_if.data.last_restart_ms);
					check_field("latest_reason", 32'(want.latest_reason),
						32'(rsp_if.data.latest_reason));
				end
			end
			if (req_if.valid && req_if.ready) begin
				verdict_queue.push_back(supervise(req_if.data));
				in_taken = 1'b1;
			end
		end
	end

	// Drop the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		cfg_t c;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_HOST_STALL;
		cfg_data = '0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		shadow = '0;
		thresholds.host_stall_ms = HOST_STALL_RST;
		thresholds.capture_task_stall_ms = CAP_TASK_RST;
		thresholds.capture_frame_stall_ms = CAP_FRAME_RST;
		thresholds.frontend_stall_ms = FRONTEND_RST;
		thresholds.healthy_window_ms = HEALTHY_WIN_RST;
		thresholds.restart_limit = RESTART_LIMIT_RST;
		thresholds.report_holdoff_ms = HOLDOFF_RST;
		scenario_ms = $urandom();
		host_mark_ms = scenario_ms;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed walk with the reset limits
		push_beat(CMD_TICK, 32'd1000, '0, '0, 1'b1, '0);        // tick while disarmed
		push_beat(CMD_POLL, 32'd500, '0, '0, 1'b0, '0);         // poll while disarmed
		push_beat(CMD_UNUSED, 32'd777, '1, '1, 1'b1, '1);       // unused command
		push_beat(CMD_START, 32'd1000, '0, '0, 1'b0, '0);
		push_beat(CMD_START, 32'd2000, '0, '0, 1'b0, '0);       // start while armed
		push_beat(CMD_TICK, 32'd3000, 32'd2500, 32'd2500, 1'b1, 32'd2500);
		push_beat(CMD_TICK, 32'd7000, 32'd6500, 32'd1000, 1'b1, 32'd6500);  // frame at limit
		push_beat(CMD_TICK, 32'd7001, 32'd6500, 32'd1000, 1'b1, 32'd6500);  // frame past limit
		push_beat(CMD_START, 32'd10000, '0, '0, 1'b0, '0);
		push_beat(CMD_TICK, 32'd11000, '0, 32'd11000, 1'b0, '0);           // task never seen
		push_beat(CMD_START, 32'd20000, '0, '0, 1'b0, '0);
		push_beat(CMD_TICK, 32'd26001, 32'd26000, 32'd26000, 1'b1, 32'd21000); // fallback
		push_beat(CMD_TICK, 32'd28000, 32'd26000, 32'd26000, 1'b0, '0);
		push_beat(CMD_TICK, 32'd35001, 32'd35000, 32'd35000, 1'b0, '0);    // host stall
		push_beat(CMD_START, 32'd40000, '0, '0, 1'b0, '0);
		push_beat(CMD_TICK, 32'd44001, 32'd40000, 32'd44000, 1'b0, '0);    // degraded
		push_beat(CMD_POLL, 32'd45000, '0, '0, 1'b0, '0);
		push_beat(CMD_TICK, 32'd46000, 32'd40000, 32'd46000, 1'b0, '0);    // held off
		push_beat(CMD_TICK, 32'd54001, 32'd40000, 32'd54000, 1'b0, '0);    // holdoff over
		push_beat(CMD_POLL, 32'd158000, '0, '0, 1'b0, '0);
		push_beat(CMD_TICK, 32'd160000, 32'd150000, 32'd160000, 1'b0, '0); // healthy window
		push_beat(CMD_START, 32'd0, '0, '0, 1'b0, '0);                     // poll stamp zero
		push_beat(CMD_TICK, 32'd5, 32'd5, 32'd5, 1'b0, '0);
		push_beat(CMD_START, 32'hFFFF_FFF0, '0, '0, 1'b0, '0);
		push_beat(CMD_TICK, 32'h10, 32'h8, 32'h8, 1'b1, 32'hFFFF_FFF8);     // time wraps
		wait_drained();

		// Moderate random limits
		apply_limits(random_limits());
		queue_sessions(300, 12, 35);
		wait_drained();

		// All limits at zero
		c = '0;
		apply_limits(c);
		queue_sessions(120, 6, 30);
		wait_drained();

		// All limits at their maximum
		c = '1;
		apply_limits(c);
		queue_sessions(120, 8, 30);
		wait_drained();

		// Drive the recovery streak into saturation
		c = '0;
		c.capture_frame_stall_ms = $urandom_range(0, 7000);
		c.frontend_stall_ms = $urandom_range(0, 6000);
		c.healthy_window_ms = '1;
		c.restart_limit = COUNT_MAX;
		c.report_holdoff_ms = $urandom_range(0, 20000);
		apply_limits(c);
		queue_sessions(700, 1, 0);
		wait_drained();

		// Fresh random limits, short healthy windows clear the streak
		repeat (2) begin
			c = random_limits();
			c.restart_limit = COUNT_W'($urandom_range(0, 255));
			apply_limits(c);
			queue_sessions(100, 10, 30);
			wait_drained();
		end

		if (fault_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/hbs_pkg.sv
rtl/hbs_in_if.sv
rtl/hbs_out_if.sv
rtl/hbs_cfg_regs.sv
rtl/hbs_eval.sv
rtl/multi_heartbeat_supervisor_unit.sv
dv/tb_top.sv
